@@ hw/rtl/i2crt_pkg.sv @@
// ----------------------------------------------------------------------------
// i2crt_pkg
// Types and constants shared by the I2C register target.
// ----------------------------------------------------------------------------
package i2crt_pkg;

  // Bits in one bus byte
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BITS_W    = 4;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DEV_ADDR_W = 7;

  // Register indexes (word index = paddr >> 2)
  localparam logic REG_TARGET_ADDR = 1'b0;

  // Bus phase codes
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDRESS = 3'd1,
    PH_SEND    = 3'd2,
    PH_RECEIVE = 3'd3,
    PH_ACK     = 3'd4,
    PH_MACK    = 3'd5
  } phase_t;

  // One result word
  typedef struct packed {
    logic       sda_out;
    logic       sda_update;
    logic       write_valid;
    logic [7:0] write_addr;
    logic [7:0] write_data;
    logic       read_strobe;
    logic [7:0] reg_pointer;
    logic       stop_seen;
  } res_t;

endpackage

@@ hw/rtl/i2crt_in_if.sv @@
// ----------------------------------------------------------------------------
// i2crt_in_if
// Input channel: one sample of the bus lines plus the register file byte.
// ----------------------------------------------------------------------------
interface i2crt_in_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic [7:0] read_data;

  modport source (output valid, output scl, output sda, output read_data, input ready);
  modport sink   (input valid, input scl, input sda, input read_data, output ready);
endinterface

@@ hw/rtl/i2crt_out_if.sv @@
// ----------------------------------------------------------------------------
// i2crt_out_if
// Result channel: SDA drive, register write request and status per sample.
// ----------------------------------------------------------------------------
interface i2crt_out_if;
  logic       valid;
  logic       ready;
  logic       sda_out;
  logic       sda_update;
  logic       write_valid;
  logic [7:0] write_addr;
  logic [7:0] write_data;
  logic       read_strobe;
  logic [7:0] reg_pointer;
  logic       stop_seen;

  modport source (
    output valid, output sda_out, output sda_update, output write_valid,
    output write_addr, output write_data, output read_strobe,
    output reg_pointer, output stop_seen, input ready
  );
  modport sink (
    input valid, input sda_out, input sda_update, input write_valid,
    input write_addr, input write_data, input read_strobe,
    input reg_pointer, input stop_seen, output ready
  );
endinterface

@@ hw/rtl/i2c_register_target_top.sv @@
// ----------------------------------------------------------------------------
// i2c_register_target_top
// Bit-level 7-bit I2C target with a one-byte register pointer.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------------------
//   in_ch    | in  | scl, sda, read_data (one line sample)
//   out_ch   | out | sda_out, sda_update, write_*, read_strobe, reg_pointer,
//            |     | stop_seen (one result per sample)
//   cfg_*    | in  | APB write/read of the target address at byte address 0
//
// One sample is taken per clock while in_ch.ready is high; its result is
// registered. Synchronous active-low reset returns the bus phase to idle, the
// pointer to zero and the line history to released. Under output stall a skid
// slot takes one more sample, then in_ch.ready drops until it drains.
// ----------------------------------------------------------------------------
module i2c_register_target_top import i2crt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  i2crt_in_if.sink              in_ch,
  i2crt_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [DEV_ADDR_W-1:0] target_addr;
  logic                  can_push;
  logic                  take;
  res_t                  res;

  // Accept a sample when the skid slot is free
  assign in_ch.ready = can_push;
  assign take        = in_ch.valid && can_push;

  i2crt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .target_addr (target_addr)
  );

  i2crt_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .scl         (in_ch.scl),
    .sda         (in_ch.sda),
    .read_data   (in_ch.read_data),
    .target_addr (target_addr),
    .res         (res)
  );

  i2crt_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_res (res),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

endmodule

@@ hw/rtl/i2crt_cfg.sv @@
// ----------------------------------------------------------------------------
// i2crt_cfg
// APB-style register block holding the target's device address.
// ----------------------------------------------------------------------------
module i2crt_cfg import i2crt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DEV_ADDR_W-1:0] target_addr
);

  logic [DEV_ADDR_W-1:0] dev_addr_r;
  logic [DEV_ADDR_W-1:0] dev_addr_nxt;
  logic                  wr_en;
  logic                  hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_ADDR_W-1] == REG_TARGET_ADDR);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  // Capture the address on the access cycle
  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (wr_en) begin
      dev_addr_nxt = pwdata[DEV_ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(CFG_DATA_W-DEV_ADDR_W){1'b0}}, dev_addr_r};
    end
  end

  assign target_addr = dev_addr_r;

endmodule

@@ hw/rtl/i2crt_engine.sv @@
// ----------------------------------------------------------------------------
// i2crt_engine
// Bus protocol state and per-sample decode: START/STOP, address, data, ACK.
// ----------------------------------------------------------------------------
module i2crt_engine import i2crt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  scl,
  input  logic                  sda,
  input  logic [7:0]            read_data,
  input  logic [DEV_ADDR_W-1:0] target_addr,
  output res_t                  res
);

  phase_t            phase_r, phase_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [7:0]        addr_sh_r, addr_sh_nxt;
  logic              rd_req_r, rd_req_nxt;
  logic              addressed_r, addressed_nxt;
  logic [7:0]        rx_sh_r, rx_sh_nxt;
  logic [7:0]        tx_sh_r, tx_sh_nxt;
  logic [7:0]        ptr_r, ptr_nxt;
  logic              exp_ptr_r, exp_ptr_nxt;
  logic              last_sda_r, last_sda_nxt;
  logic              last_scl_r, last_scl_nxt;

  logic [BITS_W-1:0] bits_dec;
  logic              rd_req_new;
  logic [7:0]        rx_new;
  logic              sdo;

  assign bits_dec   = bits_r - BITS_W'(1);
  assign rd_req_new = (bits_r > BITS_W'(1)) ? rd_req_r : sda;
  assign rx_new     = {rx_sh_r[6:0], sda};

  // Decode one sample
  always_comb begin
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    addr_sh_nxt   = addr_sh_r;
    rd_req_nxt    = rd_req_r;
    addressed_nxt = addressed_r;
    rx_sh_nxt     = rx_sh_r;
    tx_sh_nxt     = tx_sh_r;
    ptr_nxt       = ptr_r;
    exp_ptr_nxt   = exp_ptr_r;
    sdo           = 1'b1;
    res           = '0;

    if (scl && (sda != last_sda_r)) begin
      // START or STOP
      if (last_sda_r) begin
        phase_nxt   = PH_ADDRESS;
        addr_sh_nxt = '0;
        bits_nxt    = BITS_W'(BYTE_BITS);
      end else begin
        phase_nxt     = PH_IDLE;
        res.stop_seen = 1'b1;
      end
    end else if (!last_scl_r && scl) begin
      // Rising SCL: sample
      unique case (phase_r)
        PH_ADDRESS: begin
          if (bits_r > BITS_W'(1)) begin
            addr_sh_nxt = {addr_sh_r[6:0], sda};
          end else begin
            rd_req_nxt = sda;
          end
          bits_nxt = bits_dec;
          if (bits_dec == '0) begin
            bits_nxt = BITS_W'(BYTE_BITS);
            if (addr_sh_r == {1'b0, target_addr}) begin
              addressed_nxt = 1'b1;
              if (rd_req_new) begin
                tx_sh_nxt       = read_data;
                res.read_strobe = 1'b1;
                exp_ptr_nxt     = 1'b1;
              end
              phase_nxt = PH_ACK;
            end else begin
              addressed_nxt = 1'b0;
              phase_nxt     = PH_IDLE;
            end
          end
        end
        PH_RECEIVE: begin
          rx_sh_nxt = rx_new;
          bits_nxt  = bits_dec;
          if (bits_dec == '0) begin
            bits_nxt = BITS_W'(BYTE_BITS);
            if (exp_ptr_r) begin
              ptr_nxt     = rx_new;
              exp_ptr_nxt = 1'b0;
            end else begin
              res.write_valid = 1'b1;
              res.write_addr  = ptr_r;
              res.write_data  = rx_new;
              exp_ptr_nxt     = 1'b1;
            end
            phase_nxt = PH_ACK;
          end
        end
        PH_ACK: begin
          if (addressed_r) begin
            if (rd_req_r) begin
              phase_nxt = PH_SEND;
              bits_nxt  = BITS_W'(BYTE_BITS);
            end else begin
              phase_nxt = PH_RECEIVE;
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_MACK: phase_nxt = PH_IDLE;
        default: ;
      endcase
    end else if (last_scl_r && !scl) begin
      // Falling SCL: drive
      res.sda_update = 1'b1;
      unique case (phase_r)
        PH_ACK: sdo = !addressed_r;
        PH_SEND: begin
          sdo       = tx_sh_r[7];
          tx_sh_nxt = {tx_sh_r[6:0], 1'b0};
          bits_nxt  = bits_dec;
          if (bits_dec == '0) begin
            phase_nxt = PH_MACK;
          end
        end
        default: sdo = 1'b1;
      endcase
    end

    last_sda_nxt    = sda;
    last_scl_nxt    = scl;
    res.sda_out     = res.sda_update ? sdo : 1'b1;
    res.reg_pointer = ptr_nxt;
  end

  // Advance state on each taken sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bits_r      <= '0;
      addr_sh_r   <= '0;
      rd_req_r    <= 1'b0;
      addressed_r <= 1'b0;
      rx_sh_r     <= '0;
      tx_sh_r     <= '0;
      ptr_r       <= '0;
      exp_ptr_r   <= 1'b1;
      last_sda_r  <= 1'b1;
      last_scl_r  <= 1'b1;
    end else if (take) begin
      phase_r     <= phase_nxt;
      bits_r      <= bits_nxt;
      addr_sh_r   <= addr_sh_nxt;
      rd_req_r    <= rd_req_nxt;
      addressed_r <= addressed_nxt;
      rx_sh_r     <= rx_sh_nxt;
      tx_sh_r     <= tx_sh_nxt;
      ptr_r       <= ptr_nxt;
      exp_ptr_r   <= exp_ptr_nxt;
      last_sda_r  <= last_sda_nxt;
      last_scl_r  <= last_scl_nxt;
    end
  end

endmodule

@@ hw/rtl/i2crt_out_buf.sv @@
// ----------------------------------------------------------------------------
// i2crt_out_buf
// Result register with a skid slot that takes one more result under stall.
// ----------------------------------------------------------------------------
module i2crt_out_buf import i2crt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  res_t         push_res,
  output logic         can_push,
  i2crt_out_if.source  out_ch
);

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  assign can_push = !skid_vld_r;

  // Move words between slots
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_res_nxt = push_res;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.sda_out     = out_res_r.sda_out;
  assign out_ch.sda_update  = out_res_r.sda_update;
  assign out_ch.write_valid = out_res_r.write_valid;
  assign out_ch.write_addr  = out_res_r.write_addr;
  assign out_ch.write_data  = out_res_r.write_data;
  assign out_ch.read_strobe = out_res_r.read_strobe;
  assign out_ch.reg_pointer = out_res_r.reg_pointer;
  assign out_ch.stop_seen   = out_res_r.stop_seen;

endmodule

@@ tb/sv/tb_i2c_register_target_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_target_top
// Plays I2C master on sampled SCL/SDA levels, predicts the target's answer
// to every sample and checks each result word in order under random stalls.
// ----------------------------------------------------------------------------
module tb_i2c_register_target_top;
  import i2crt_pkg::*;

  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_ADDR_W-1:0] DEV_ADDR_OFFSET = CFG_ADDR_W'({REG_TARGET_ADDR, 2'b00});

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  i2crt_in_if  in_ch ();
  i2crt_out_if out_ch ();

  i2c_register_target_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predicted target state
  phase_t      bus_state   = PH_IDLE;
  logic [3:0]  bits_to_go  = '0;
  logic [7:0]  hdr_shift   = '0;
  logic        is_read     = 1'b0;
  logic        selected    = 1'b0;
  logic [7:0]  rx_byte     = '0;
  logic [7:0]  tx_byte     = '0;
  logic [7:0]  reg_ptr     = '0;
  logic        ptr_next    = 1'b1;
  logic        prev_sda    = 1'b1;
  logic        prev_scl    = 1'b1;
  logic [6:0]  own_addr    = '0;

  // Stimulus bookkeeping
  res_t        pending_responses[$];
  int unsigned fail_count       = 0;
  int unsigned samples_accepted = 0;
  int unsigned in_gap_pct       = 0;
  int unsigned out_stall_pct    = 0;
  int          forced_read      = -1;
  bit          cur_scl          = 1'b1;
  bit          cur_sda          = 1'b1;

  always #6 clk = ~clk;

  // Compute the target's answer to one line sample and advance its state
  function automatic res_t target_response(bit scl, bit sda, logic [7:0] rd);
    res_t r;
    r = '0;
    r.sda_out = 1'b1;
    if (scl && (sda != prev_sda)) begin
      // SDA moved under high SCL: START or STOP, no clock edge handled
      if (prev_sda) begin
        bus_state  = PH_ADDRESS;
        hdr_shift  = '0;
        bits_to_go = BITS_W'(BYTE_BITS);
      end else begin
        bus_state   = PH_IDLE;
        r.stop_seen = 1'b1;
      end
    end else if (!prev_scl && scl) begin
      case (bus_state)
        PH_ADDRESS: begin
          if (bits_to_go > 4'd1) hdr_shift = {hdr_shift[6:0], sda};
          else is_read = sda;
          bits_to_go = bits_to_go - 4'd1;
          if (bits_to_go == 4'd0) begin
            bits_to_go = BITS_W'(BYTE_BITS);
            if (hdr_shift == {1'b0, own_addr}) begin
              selected = 1'b1;
              if (is_read) begin
                tx_byte       = rd;
                r.read_strobe = 1'b1;
                ptr_next      = 1'b1;
              end
              bus_state = PH_ACK;
            end else begin
              selected  = 1'b0;
              bus_state = PH_IDLE;
            end
          end
        end
        PH_RECEIVE: begin
          rx_byte    = {rx_byte[6:0], sda};
          bits_to_go = bits_to_go - 4'd1;
          if (bits_to_go == 4'd0) begin
            bits_to_go = BITS_W'(BYTE_BITS);
            // Alternate pointer byte and data byte
            if (ptr_next) begin
              reg_ptr  = rx_byte;
              ptr_next = 1'b0;
            end else begin
              r.write_valid = 1'b1;
              r.write_addr  = reg_ptr;
              r.write_data  = rx_byte;
              ptr_next      = 1'b1;
            end
            bus_state = PH_ACK;
          end
        end
        PH_ACK: begin
          if (!selected) begin
            bus_state = PH_IDLE;
          end else if (is_read) begin
            bus_state  = PH_SEND;
            bits_to_go = BITS_W'(BYTE_BITS);
          end else begin
            bus_state = PH_RECEIVE;
          end
        end
        PH_MACK: bus_state = PH_IDLE;
        default: ;
      endcase
    end else if (prev_scl && !scl) begin
      r.sda_update = 1'b1;
      case (bus_state)
        PH_ACK: r.sda_out = !selected;
        PH_SEND: begin
          r.sda_out  = tx_byte[7];
          tx_byte    = {tx_byte[6:0], 1'b0};
          bits_to_go = bits_to_go - 4'd1;
          if (bits_to_go == 4'd0) bus_state = PH_MACK;
        end
        default: r.sda_out = 1'b1;
      endcase
    end
    prev_sda = sda;
    prev_scl = scl;
    r.reg_pointer = reg_ptr;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_responses
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("sda_out", 8'(want.sda_out), 8'(out_ch.sda_out));
        check_field("sda_update", 8'(want.sda_update), 8'(out_ch.sda_update));
        check_field("write_valid", 8'(want.write_valid), 8'(out_ch.write_valid));
        check_field("write_addr", want.write_addr, out_ch.write_addr);
        check_field("write_data", want.write_data, out_ch.write_data);
        check_field("read_strobe", 8'(want.read_strobe), 8'(out_ch.read_strobe));
        check_field("reg_pointer", want.reg_pointer, out_ch.reg_pointer);
        check_field("stop_seen", 8'(want.stop_seen), 8'(out_ch.stop_seen));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Send one line sample, idling first at random
  task automatic put_lines(bit scl, bit sda);
    logic [7:0] rd;
    rd = (forced_read >= 0) ? 8'(forced_read) : 8'($urandom_range(255));
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.scl       <= scl;
    in_ch.sda       <= sda;
    in_ch.read_data <= rd;
    do @(posedge clk); while (!in_ch.ready);
    pending_responses.push_back(target_response(scl, sda, rd));
    samples_accepted++;
    cur_scl = scl;
    cur_sda = sda;
  endtask

  // Hold the sender until every predicted word has come back
  task automatic wait_for_responses();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // APB write of the device address; only while the target is idle
  task automatic set_target_addr(logic [6:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DEV_ADDR_OFFSET;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    own_addr = value;
  endtask

  task automatic bus_start();
    if (!(cur_scl && cur_sda)) begin
      put_lines(1'b0, 1'b1);
      put_lines(1'b1, 1'b1);
    end
    put_lines(1'b1, 1'b0);
  endtask

  task automatic bus_stop();
    put_lines(1'b0, 1'b0);
    put_lines(1'b1, 1'b0);
    put_lines(1'b1, 1'b1);
  endtask

  // One bit: SDA set with SCL low, then held across the high sample
  task automatic bus_bit(bit b);
    put_lines(1'b0, b);
    put_lines(1'b1, b);
  endtask

  // Eight bits MSB first plus the acknowledge slot
  task automatic bus_byte(logic [7:0] v);
    for (int i = 7; i >= 0; i--) bus_bit(v[i]);
    bus_bit(1'($urandom_range(1)));
  endtask

  // End with STOP mostly, else leave the bus for a repeated START
  task automatic bus_finish();
    if ($urandom_range(99) < 75) bus_stop();
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [6:0] pick_addr();
    if ($urandom_range(99) < 85) return own_addr;
    return 7'($urandom_range(127));
  endfunction

  task automatic test_write_extremes();
    bus_start();
    bus_byte({own_addr, 1'b0});
    bus_byte(8'hFF);
    bus_byte(8'h00);
    bus_byte(8'h00);
    bus_byte(8'hFF);
    bus_stop();
  endtask

  // Two reads back to back through a repeated START; the master ack bit is random
  task automatic test_read_repeated_start();
    forced_read = 8'hFF;
    bus_start();
    bus_byte({own_addr, 1'b1});
    bus_byte(8'h00);
    forced_read = 8'h00;
    bus_start();
    bus_byte({own_addr, 1'b1});
    bus_byte(8'hFF);
    bus_stop();
    forced_read = -1;
  endtask

  task automatic test_address_mismatch();
    bus_start();
    bus_byte({~own_addr, 1'b0});
    bus_byte(8'hA5);
    bus_stop();
  endtask

  // START and STOP that arrive on the same sample as a rising SCL
  task automatic test_conditions_on_rising_scl();
    put_lines(1'b0, 1'b1);
    put_lines(1'b1, 1'b0);
    bus_byte({own_addr, 1'b0});
    bus_byte(8'h5A);
    put_lines(1'b0, 1'b0);
    put_lines(1'b1, 1'b1);
  endtask

  // Abort a byte with STOP; the next byte still lands as data
  task automatic test_stop_mid_byte();
    bus_start();
    bus_byte({own_addr, 1'b0});
    repeat (3) bus_bit(1'b1);
    bus_stop();
    bus_start();
    bus_byte({own_addr, 1'b0});
    bus_byte(8'h3C);
    bus_stop();
  endtask

  task automatic test_address_zero();
    wait_for_responses();
    set_target_addr(7'h00);
    bus_start();
    bus_byte(8'h00);
    bus_byte(8'h81);
    bus_byte(8'h7E);
    bus_stop();
    bus_start();
    bus_byte(8'h01);
    bus_byte(8'h00);
    bus_stop();
  endtask

  // Mostly well-formed transfers with random content, some broken ones and noise
  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                     int unsigned n_samples);
    int unsigned stop_at;
    int unsigned pick;
    wait_for_responses();
    set_target_addr(7'($urandom_range(127)));
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    stop_at = samples_accepted + n_samples;
    while (samples_accepted < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        bus_start();
        bus_byte({pick_addr(), 1'b0});
        repeat ($urandom_range(1, 4)) bus_byte(pick_byte());
        bus_finish();
      end else if (pick < 78) begin
        bus_start();
        bus_byte({pick_addr(), 1'b1});
        bus_byte(pick_byte());
        bus_finish();
      end else if (pick < 86) begin
        bus_start();
        bus_byte({own_addr ^ 7'($urandom_range(1, 127)), 1'($urandom_range(1))});
        bus_byte(pick_byte());
        bus_stop();
      end else if (pick < 94) begin
        bus_start();
        bus_byte({pick_addr(), 1'($urandom_range(1))});
        repeat ($urandom_range(0, 7)) bus_bit(1'($urandom_range(1)));
        bus_stop();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          put_lines(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
      if ($urandom_range(99) < 4) wait_for_responses();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.scl       = 1'b1;
    in_ch.sda       = 1'b1;
    in_ch.read_data = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct    = 7;
    out_stall_pct = 81;
    set_target_addr(7'h7F);
    test_write_extremes();
    test_read_repeated_start();
    test_address_mismatch();
    test_conditions_on_rising_scl();
    test_stop_mid_byte();
    test_address_zero();

    test_random_traffic(7, 81, 10);
    test_random_traffic(81, 7, 10);
    test_random_traffic(0, 0, 10);

    // Drain, then let any stray word show up
    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/i2crt_pkg.sv
hw/rtl/i2crt_in_if.sv
hw/rtl/i2crt_out_if.sv
hw/rtl/i2crt_cfg.sv
hw/rtl/i2crt_engine.sv
hw/rtl/i2crt_out_buf.sv
hw/rtl/i2c_register_target_top.sv
tb/sv/tb_i2c_register_target_top.sv
